@@ rtl/core/fbpm_pkg.sv @@
// Shared types and codes for the frame buffer pool manager.
// Used by fbpm_queue, the top level and the testbench; depends on nothing else.
package fbpm_pkg;

  // Operation codes carried by an input word.
  localparam logic [2:0] OP_INIT     = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_FREE_ENQ = 3'd2;
  localparam logic [2:0] OP_BUSY_ENQ = 3'd3;
  localparam logic [2:0] OP_FREE_DEQ = 3'd4;
  localparam logic [2:0] OP_BUSY_DEQ = 3'd5;

  // Result status codes.
  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_EMPTY    = 2'd1;
  localparam logic [1:0] RS_OVERFLOW = 2'd2;

  // Per-buffer status codes.
  localparam logic [1:0] BS_UNDEF  = 2'd0;
  localparam logic [1:0] BS_FREE   = 2'd1;
  localparam logic [1:0] BS_BUSY   = 2'd2;
  localparam logic [1:0] BS_LEASED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BUFFER_COUNT = 1'b0;
  localparam logic CFG_LEASE_TIMEOUT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  BUFFER_COUNT_RESET  = 8'd4;
  localparam logic [15:0] LEASE_TIMEOUT_RESET = 16'd3000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_POP,
    ST_LEASE,
    ST_FIN
  } state_t;

  // Control of one index queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

@@ rtl/core/fbpm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing else.
module fbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fbpm_queue.sv @@
// Circular index queue: storage RAM plus head, tail and fill count registers.
// Depends on fbpm_pkg and fbpm_ram.
module fbpm_queue #(
  parameter int DEPTH = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fbpm_pkg::q_ctrl_t           ctrl,
  input  logic [$clog2(DEPTH)-1:0]    push_data,
  output logic [$clog2(DEPTH)-1:0]    pop_data,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  output logic                        full,
  output logic                        empty
);
  import fbpm_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = ctrl.push && !full;
  assign pop_ok  = ctrl.pop && !empty;

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        tail <= (tail == IW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop_ok) begin
        head <= (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

  // Pop data appears in the cycle after the pop.
  fbpm_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail),
    .wdata (push_data),
    .raddr (head),
    .rdata (pop_data)
  );

endmodule

@@ rtl/core/frame_buffer_pool_manager.sv @@
// Top level of the frame buffer pool manager: sequencer, buffer status and
// lease expiry RAMs, clock and counters. Depends on fbpm_pkg, fbpm_queue, fbpm_ram.
//
//   channel  signals                                   direction
//   input    in_valid, in_stall, op, buffer_index      word in
//   result   out_valid, out_stall, status ... counters word out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data write in
//
// A dequeue runs an expiry scan that reads one buffer per cycle from the status
// and expiry RAMs, then pops its queue and, when that queue is not empty, writes
// the lease. Init makes one status write per buffer. After reset a clearing pass
// sets every buffer status to undefined before the first word is taken.
// A result waits in the output register while the next word runs; if it is
// still stalled when that word finishes, the block holds and in_stall stays high.
module frame_buffer_pool_manager #(
  parameter int MAX_BUFFERS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [6:0]  buffer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  granted_index,
  output logic [7:0]  free_count,
  output logic [7:0]  ready_count,
  output logic [31:0] reclaimed_total,
  output logic [31:0] producer_starved,
  output logic [31:0] consumer_starved,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import fbpm_pkg::*;

  localparam int IW = $clog2(MAX_BUFFERS);
  localparam int CW = $clog2(MAX_BUFFERS + 1);
  localparam int NW = (CW > 8) ? CW : 8;

  state_t state;
  state_t state_next;

  logic [7:0]    buffer_count;
  logic [15:0]   lease_timeout_ms;
  logic [31:0]   clock_ms;
  logic [31:0]   reclaimed;
  logic [31:0]   prod_starved;
  logic [31:0]   cons_starved;
  logic [2:0]    op_r;
  logic [1:0]    status_r;
  logic [IW-1:0] granted_r;
  logic [CW-1:0] idx;
  logic          ev_valid;
  logic [IW-1:0] ev_idx;

  logic [NW-1:0] bc_ext;
  logic [CW-1:0] pool;
  logic          accept;
  logic          busy_q;
  logic          reclaim;
  logic [31:0]   age;
  logic          out_load;

  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [1:0]    st_wdata;
  logic [1:0]    st_rdata;
  logic          ex_we;
  logic [31:0]   ex_rdata;

  q_ctrl_t       fq_ctrl;
  q_ctrl_t       rq_ctrl;
  logic [IW-1:0] fq_push_data;
  logic [IW-1:0] fq_pop_data;
  logic [IW-1:0] rq_pop_data;
  logic [CW-1:0] fq_count;
  logic [CW-1:0] rq_count;
  logic          fq_full;
  logic          rq_full;
  logic          fq_empty;
  logic          rq_empty;

  // Effective pool size: buffer_count saturated into 4..MAX_BUFFERS.
  assign bc_ext = NW'(buffer_count);
  always_comb begin
    if (bc_ext < NW'(4)) begin
      pool = CW'(4);
    end else if (bc_ext > NW'(MAX_BUFFERS)) begin
      pool = CW'(MAX_BUFFERS);
    end else begin
      pool = CW'(bc_ext);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign busy_q    = (op_r == OP_BUSY_DEQ);
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  // A leased buffer is reclaimed when its expiry lies strictly in the past.
  assign age     = clock_ms - ex_rdata;
  assign reclaim = ev_valid && (st_rdata == BS_LEASED) && (age != '0) && !age[31];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory and queue controls.
  always_comb begin
    state_next   = state;
    st_we        = 1'b0;
    st_waddr     = idx[IW-1:0];
    st_wdata     = BS_UNDEF;
    ex_we        = 1'b0;
    fq_ctrl      = '0;
    rq_ctrl      = '0;
    fq_push_data = idx[IW-1:0];

    // Reclaim writes land while the scan or its last step runs.
    if (reclaim) begin
      st_we        = 1'b1;
      st_waddr     = ev_idx;
      st_wdata     = BS_FREE;
      fq_ctrl.push = 1'b1;
      fq_push_data = ev_idx;
    end

    unique case (state)
      ST_CLEAR: begin
        st_we = 1'b1;
        if (idx == CW'(MAX_BUFFERS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INIT: begin
              fq_ctrl.clear = 1'b1;
              rq_ctrl.clear = 1'b1;
              state_next    = ST_INIT;
            end
            OP_FREE_ENQ, OP_BUSY_ENQ: begin
              if (NW'(buffer_index) < NW'(pool)) begin
                st_we        = 1'b1;
                st_waddr     = IW'(buffer_index);
                st_wdata     = (op == OP_BUSY_ENQ) ? BS_BUSY : BS_FREE;
                fq_push_data = IW'(buffer_index);
                fq_ctrl.push = (op == OP_FREE_ENQ);
                rq_ctrl.push = (op == OP_BUSY_ENQ);
              end
              state_next = ST_FIN;
            end
            OP_FREE_DEQ, OP_BUSY_DEQ: begin
              state_next = ST_SCAN;
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_INIT: begin
        st_we = 1'b1;
        if (idx < pool) begin
          st_wdata     = BS_FREE;
          fq_ctrl.push = 1'b1;
        end
        if (idx == CW'(MAX_BUFFERS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (idx == pool - 1'b1) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        if (busy_q ? rq_empty : fq_empty) begin
          state_next = ST_FIN;
        end else begin
          fq_ctrl.pop = !busy_q;
          rq_ctrl.pop = busy_q;
          state_next  = ST_LEASE;
        end
      end
      ST_LEASE: begin
        st_we      = 1'b1;
        st_waddr   = busy_q ? rq_pop_data : fq_pop_data;
        st_wdata   = BS_LEASED;
        ex_we      = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count     <= BUFFER_COUNT_RESET;
      lease_timeout_ms <= LEASE_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUFFER_COUNT:  buffer_count     <= cfg_data[7:0];
        CFG_LEASE_TIMEOUT: lease_timeout_ms <= cfg_data;
        default:           buffer_count     <= buffer_count;
      endcase
    end
  end

  // Sweep index, scan pipeline, clock and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      ev_valid     <= 1'b0;
      clock_ms     <= '0;
      reclaimed    <= '0;
      prod_starved <= '0;
      cons_starved <= '0;
    end else begin
      ev_valid <= (state == ST_SCAN);
      if (reclaim) begin
        reclaimed <= reclaimed + 1'b1;
      end
      unique case (state)
        ST_CLEAR, ST_INIT, ST_SCAN: begin
          idx <= idx + 1'b1;
        end
        ST_IDLE: begin
          idx <= '0;
          if (accept && op == OP_INIT) begin
            reclaimed    <= '0;
            prod_starved <= '0;
            cons_starved <= '0;
          end
          if (accept && op == OP_TICK) begin
            clock_ms <= clock_ms + 1'b1;
          end
        end
        ST_POP: begin
          if (busy_q && rq_empty) begin
            cons_starved <= cons_starved + 1'b1;
          end
          if (!busy_q && fq_empty) begin
            prod_starved <= prod_starved + 1'b1;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Per-word result fields.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      ev_idx <= idx[IW-1:0];
    end
    if (accept) begin
      op_r      <= op;
      granted_r <= '0;
      status_r  <= RS_OK;
      if ((op == OP_FREE_ENQ && fq_full) || (op == OP_BUSY_ENQ && rq_full)) begin
        if (NW'(buffer_index) < NW'(pool)) begin
          status_r <= RS_OVERFLOW;
        end
      end
    end
    if (state == ST_POP && (busy_q ? rq_empty : fq_empty)) begin
      status_r <= RS_EMPTY;
    end
    if (state == ST_LEASE) begin
      granted_r <= busy_q ? rq_pop_data : fq_pop_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status           <= status_r;
      granted_index    <= 7'(granted_r);
      free_count       <= 8'(fq_count);
      ready_count      <= 8'(rq_count);
      reclaimed_total  <= reclaimed;
      producer_starved <= prod_starved;
      consumer_starved <= cons_starved;
    end
  end

  // Buffer status RAM: read by the scan, written by clear, init, enqueue, lease and reclaim.
  fbpm_ram #(.WIDTH(2), .DEPTH(MAX_BUFFERS)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (idx[IW-1:0]),
    .rdata (st_rdata)
  );

  // Lease expiry RAM: written on a grant, read by the scan.
  fbpm_ram #(.WIDTH(32), .DEPTH(MAX_BUFFERS)) u_expiry_ram (
    .clk   (clk),
    .we    (ex_we),
    .waddr (st_waddr),
    .wdata (clock_ms + {16'b0, lease_timeout_ms}),
    .raddr (idx[IW-1:0]),
    .rdata (ex_rdata)
  );

  // Free queue.
  fbpm_queue #(.DEPTH(MAX_BUFFERS)) u_free_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fq_ctrl),
    .push_data (fq_push_data),
    .pop_data  (fq_pop_data),
    .count     (fq_count),
    .full      (fq_full),
    .empty     (fq_empty)
  );

  // Ready (busy) queue.
  fbpm_queue #(.DEPTH(MAX_BUFFERS)) u_ready_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rq_ctrl),
    .push_data (IW'(buffer_index)),
    .pop_data  (rq_pop_data),
    .count     (rq_count),
    .full      (rq_full),
    .empty     (rq_empty)
  );

endmodule

@@ sim/tb_frame_buffer_pool_manager.sv @@
// Testbench for the frame buffer pool manager: drives op words with random
// bursts and gaps, stalls the result side, and checks every result word
// against a cycle-free model of the pool. Depends on fbpm_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_frame_buffer_pool_manager;
  import fbpm_pkg::*;

  localparam int POOL_MAX = 128;
  localparam int CYCLE_LIMIT = 3000000;
  // Longest word: a dequeue over the largest pool, with margin.
  localparam int DRAIN_CYCLES = POOL_MAX + 40;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  granted_index;
    logic [7:0]  free_count;
    logic [7:0]  ready_count;
    logic [31:0] reclaimed_total;
    logic [31:0] producer_starved;
    logic [31:0] consumer_starved;
  } pool_result_t;

  // Pool model and the queue of result words it has predicted.
  class pool_scoreboard;
    logic [6:0]  q_store[2][POOL_MAX];
    int          q_head[2];
    int          q_tail[2];
    int          q_cnt[2];
    logic [1:0]  buf_state[POOL_MAX];
    logic [31:0] expiry[POOL_MAX];
    logic [31:0] now_ms;
    logic [31:0] n_reclaimed;
    logic [31:0] n_prod_starved;
    logic [31:0] n_cons_starved;
    logic [7:0]  cfg_count;
    logic [15:0] cfg_timeout;
    pool_result_t pending_words[$];
    int errors;
    int checked;

    function void init_state();
      for (int i = 0; i < POOL_MAX; i++) begin
        buf_state[i] = BS_UNDEF;
        expiry[i] = '0;
      end
      for (int q = 0; q < 2; q++) begin
        q_head[q] = 0;
        q_tail[q] = 0;
        q_cnt[q] = 0;
      end
      now_ms = '0;
      n_reclaimed = '0;
      n_prod_starved = '0;
      n_cons_starved = '0;
      cfg_count = BUFFER_COUNT_RESET;
      cfg_timeout = LEASE_TIMEOUT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function int pool_size();
      int n;
      n = cfg_count;
      if (n < 4) n = 4;
      if (n > POOL_MAX) n = POOL_MAX;
      return n;
    endfunction

    function bit push_index(int q, int idx);
      if (q_cnt[q] >= POOL_MAX) return 0;
      q_store[q][q_tail[q]] = idx[6:0];
      q_tail[q] = (q_tail[q] + 1) % POOL_MAX;
      q_cnt[q]++;
      return 1;
    endfunction

    function void set_register(logic idx, logic [15:0] data);
      if (idx == CFG_BUFFER_COUNT) cfg_count = data[7:0];
      else cfg_timeout = data;
    endfunction

    // Work out the result word for one accepted input word.
    function void note_word(logic [2:0] op_code, logic [6:0] bidx);
      pool_result_t r;
      int n;
      int q;
      int idx;
      bit ok;
      logic [31:0] age;
      n = pool_size();
      r.status = RS_OK;
      r.granted_index = '0;
      case (op_code)
        OP_INIT: begin
          for (int k = 0; k < 2; k++) begin
            q_head[k] = 0;
            q_tail[k] = 0;
            q_cnt[k] = 0;
          end
          n_reclaimed = '0;
          n_prod_starved = '0;
          n_cons_starved = '0;
          for (int i = 0; i < POOL_MAX; i++) buf_state[i] = BS_UNDEF;
          for (int i = 0; i < n; i++) begin
            buf_state[i] = BS_FREE;
            ok = push_index(0, i);
          end
        end
        OP_TICK: now_ms = now_ms + 1;
        OP_FREE_ENQ, OP_BUSY_ENQ: begin
          if (bidx < n) begin
            q = (op_code == OP_BUSY_ENQ) ? 1 : 0;
            buf_state[bidx] = q ? BS_BUSY : BS_FREE;
            if (!push_index(q, bidx)) r.status = RS_OVERFLOW;
          end
        end
        OP_FREE_DEQ, OP_BUSY_DEQ: begin
          q = (op_code == OP_BUSY_DEQ) ? 1 : 0;
          // Expired leases go back to the free queue before the pop.
          for (int i = 0; i < n; i++) begin
            if (buf_state[i] == BS_LEASED) begin
              age = now_ms - expiry[i];
              if (age != 0 && age[31] == 1'b0) begin
                buf_state[i] = BS_FREE;
                ok = push_index(0, i);
                n_reclaimed = n_reclaimed + 1;
              end
            end
          end
          if (q_cnt[q] > 0) begin
            idx = q_store[q][q_head[q]];
            q_head[q] = (q_head[q] + 1) % POOL_MAX;
            q_cnt[q]--;
            buf_state[idx] = BS_LEASED;
            expiry[idx] = now_ms + cfg_timeout;
            r.granted_index = idx[6:0];
          end else begin
            r.status = RS_EMPTY;
            if (q) n_cons_starved = n_cons_starved + 1;
            else n_prod_starved = n_prod_starved + 1;
          end
        end
        default: ;
      endcase
      r.free_count = q_cnt[0][7:0];
      r.ready_count = q_cnt[1][7:0];
      r.reclaimed_total = n_reclaimed;
      r.producer_starved = n_prod_starved;
      r.consumer_starved = n_cons_starved;
      pending_words.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      errors++;
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_word(pool_result_t got);
      pool_result_t want;
      if (pending_words.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
        return;
      end
      want = pending_words.pop_front();
      checked++;
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.granted_index !== want.granted_index)
        report("granted_index", want.granted_index, got.granted_index);
      if (got.free_count !== want.free_count)
        report("free_count", want.free_count, got.free_count);
      if (got.ready_count !== want.ready_count)
        report("ready_count", want.ready_count, got.ready_count);
      if (got.reclaimed_total !== want.reclaimed_total)
        report("reclaimed_total", want.reclaimed_total, got.reclaimed_total);
      if (got.producer_starved !== want.producer_starved)
        report("producer_starved", want.producer_starved, got.producer_starved);
      if (got.consumer_starved !== want.consumer_starved)
        report("consumer_starved", want.consumer_starved, got.consumer_starved);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [6:0]  buffer_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [6:0]  granted_index;
  logic [7:0]  free_count;
  logic [7:0]  ready_count;
  logic [31:0] reclaimed_total;
  logic [31:0] producer_starved;
  logic [31:0] consumer_starved;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  pool_scoreboard sb;
  int cycles;
  int words_sent;
  int burst_left;
  int stall_mode;

  frame_buffer_pool_manager u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .buffer_index(buffer_index),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_index(granted_index), .free_count(free_count), .ready_count(ready_count),
    .reclaimed_total(reclaimed_total), .producer_starved(producer_starved),
    .consumer_starved(consumer_starved),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_frame_buffer_pool_manager failed");
      $finish;
    end
  end

  // Receiver stall pattern in one of four random modes.
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ((cycles % 7) < 3);
    endcase
  end

  // Result monitor.
  always @(posedge clk) begin
    pool_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status;
      got.granted_index = granted_index;
      got.free_count = free_count;
      got.ready_count = ready_count;
      got.reclaimed_total = reclaimed_total;
      got.producer_starved = producer_starved;
      got.consumer_starved = consumer_starved;
      sb.check_word(got);
    end
  end

  // Send one input word; the sender works in bursts with random gaps.
  task automatic send_word(logic [2:0] op_code, logic [6:0] bidx);
    int gap;
    in_valid <= 1'b1;
    op <= op_code;
    buffer_index <= bidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op_code, bidx);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let the block go idle, then write one register.
  task automatic write_register(logic idx, logic [15:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // One random word, weighted toward enqueue and dequeue traffic.
  task automatic send_random_word();
    int pick;
    int n;
    logic [6:0] bidx;
    n = sb.pool_size();
    pick = $urandom_range(0, 99);
    bidx = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, n - 1));
    if (pick < 2) send_word(OP_INIT, bidx);
    else if (pick < 4) send_word(3'($urandom_range(6, 7)), bidx);
    else if (pick < 28) send_word(OP_TICK, bidx);
    else if (pick < 43) send_word(OP_FREE_ENQ, bidx);
    else if (pick < 58) send_word(OP_BUSY_ENQ, bidx);
    else if (pick < 80) send_word(OP_FREE_DEQ, bidx);
    else send_word(OP_BUSY_DEQ, bidx);
  endtask

  initial begin
    logic [15:0] phase_count[8];
    logic [15:0] phase_timeout[8];
    sb = new();
    sb.init_state();
    cycles = 0;
    words_sent = 0;
    burst_left = 0;
    stall_mode = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    buffer_index = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pops, unused codes, ignored index, init and grants.
    send_word(OP_FREE_DEQ, 7'd0);
    send_word(OP_BUSY_DEQ, 7'd127);
    send_word(3'd6, 7'd0);
    send_word(3'd7, 7'd127);
    send_word(OP_FREE_ENQ, 7'd127);
    send_word(OP_FREE_ENQ, 7'd0);
    send_word(OP_INIT, 7'd0);
    repeat (5) send_word(OP_FREE_DEQ, 7'd0);
    send_word(OP_BUSY_ENQ, 7'd3);
    send_word(OP_BUSY_ENQ, 7'd0);
    send_word(OP_BUSY_DEQ, 7'd0);
    send_word(OP_TICK, 7'd0);
    send_word(OP_BUSY_DEQ, 7'd0);
    // Zero lease: a grant expires one tick later and is reclaimed.
    write_register(CFG_LEASE_TIMEOUT, 16'd0);
    send_word(OP_INIT, 7'd0);
    send_word(OP_FREE_DEQ, 7'd0);
    send_word(OP_TICK, 7'd0);
    send_word(OP_FREE_DEQ, 7'd0);
    send_word(OP_TICK, 7'd0);
    send_word(OP_BUSY_DEQ, 7'd0);

    // Random phases over pool sizes and lease lengths, extremes included.
    phase_count = '{16'd4, 16'd0, 16'd255, 16'd16, 16'd7, 16'd128, 16'd9, 16'hFF00};
    phase_timeout = '{16'd1, 16'd5, 16'd2, 16'd20, 16'hFFFF, 16'd3, 16'd0, 16'd8};
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_BUFFER_COUNT, (p == 7) ? 16'($urandom_range(0, 255)) | 16'hFF00
                                                : phase_count[p]);
      write_register(CFG_LEASE_TIMEOUT, phase_timeout[p]);
      send_word(OP_INIT, 7'd0);
      // Full pool: push past the free and busy queue limits.
      if (sb.pool_size() == POOL_MAX) begin
        repeat (3) send_word(OP_FREE_ENQ, 7'($urandom_range(0, 127)));
        repeat (131) send_word(OP_BUSY_ENQ, 7'($urandom_range(0, 127)));
        repeat (3) send_word(OP_FREE_DEQ, 7'd0);
        repeat (3) send_word(OP_BUSY_DEQ, 7'd0);
      end
      repeat (p == 5 ? 90 : 230) send_random_word();
    end
    // Shrink the pool under live queues so pops beyond the size occur.
    write_register(CFG_BUFFER_COUNT, 16'd4);
    repeat (60) send_random_word();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words and checked %0d results over several pool sizes", words_sent,
             sb.checked);
    $display("and lease lengths, with overflow, starvation and reclaim cases.");
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb_frame_buffer_pool_manager passed");
    end else begin
      $display("tb_frame_buffer_pool_manager failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/fbpm_pkg.sv
rtl/core/fbpm_ram.sv
rtl/core/fbpm_queue.sv
rtl/core/frame_buffer_pool_manager.sv
sim/tb_frame_buffer_pool_manager.sv
